[sv/bbcm_pkg.sv]
// package for the block buffer cache manager: sizes, codes and payload types
`default_nettype none
package bbcm_pkg;
  localparam int NumBuffers = 16;
  localparam int HashBuckets = 32;
  localparam int SlotW = $clog2(NumBuffers);
  localparam int LinkW = $clog2(NumBuffers + 1);
  localparam int BucketW = (HashBuckets > 1) ? $clog2(HashBuckets) : 1;
  localparam logic [LinkW-1:0] NilLink = LinkW'(NumBuffers);

  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdWrite   = 2'd2;
  localparam logic [1:0] CmdStatus  = 2'd3;

  localparam logic [2:0] StHit      = 3'd0;
  localparam logic [2:0] StAssigned = 3'd1;
  localparam logic [2:0] StBusy     = 3'd2;
  localparam logic [2:0] StNoneFree = 3'd3;
  localparam logic [2:0] StWriteback = 3'd4;
  localparam logic [2:0] StNotLocked = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] block_number;
    logic [3:0]  buffer_index;
    logic        set_valid_flag;
    logic        set_delayed_flag;
  } bbcm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        data_is_valid;
    logic [31:0] victim_block;
  } bbcm_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request, start walk at bucket head
    logic step;     // advance walk pointer
    logic act;      // perform the command with walk result
  } bbcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_get;
    logic walk_done;
  } bbcm_stat_t;
endpackage
`default_nettype wire

[sv/bbcm_ctrl.sv]
// controller for the block buffer cache manager
`default_nettype none
module bbcm_ctrl import bbcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output bbcm_cmd_t ctl,
  input  bbcm_stat_t sts
);
  typedef enum logic [1:0] {Idle, Walk, Act, Hold} state_t;
  state_t state_r, state_nxt;
  logic out_valid_nxt;

  assign in_stall = (state_r != Idle);
  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid;
    unique case (state_r)
      Idle: if (in_valid) begin
        ctl.load = 1'b1;
        state_nxt = Walk;
      end
      Walk: if (!sts.is_get || sts.walk_done) state_nxt = Act;
            else ctl.step = 1'b1;
      Act: begin
        ctl.act = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = Hold;
      end
      Hold: if (!out_stall) begin
        out_valid_nxt = 1'b0;
        state_nxt = Idle;
      end
      default: state_nxt = Idle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Idle;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

[sv/bbcm_dp.sv]
// datapath for the block buffer cache manager: headers, lists and chain walk
`default_nettype none
module bbcm_dp import bbcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  bbcm_in_t  in_req,
  input  bbcm_cmd_t ctl,
  output bbcm_stat_t sts,
  output bbcm_out_t out_res
);
  logic [31:0]      tag_r [NumBuffers];
  logic [NumBuffers-1:0] pres_r, lock_r, cv_r, dw_r, wb_r, onf_r;
  logic [LinkW-1:0] fn_r [NumBuffers];
  logic [LinkW-1:0] fp_r [NumBuffers];
  logic [LinkW-1:0] cn_r [NumBuffers];
  logic [LinkW-1:0] cp_r [NumBuffers];
  logic [LinkW-1:0] bh_r [HashBuckets];
  logic [LinkW-1:0] fh_r, ft_r;
  bbcm_in_t         req_r;
  logic [LinkW-1:0] ptr_r;
  logic [LinkW:0]   cnt_r;
  logic             hit_r;

  function automatic logic [BucketW-1:0] bkt(input logic [31:0] b);
    return BucketW'(b % 32'(HashBuckets));
  endfunction

  logic ptr_ok, match;
  logic [SlotW-1:0] pi;
  assign pi = ptr_r[SlotW-1:0];
  assign ptr_ok = ptr_r < NilLink;
  assign match = ptr_ok && pres_r[pi] && tag_r[pi] == req_r.block_number;
  assign sts.is_get = req_r.cmd == CmdGet;
  assign sts.walk_done = hit_r || !ptr_ok || cnt_r >= (LinkW+1)'(NumBuffers);

  // scratch copies for the command update
  logic [LinkW-1:0] fn [NumBuffers];
  logic [LinkW-1:0] fp [NumBuffers];
  logic [LinkW-1:0] cn [NumBuffers];
  logic [LinkW-1:0] cp [NumBuffers];
  logic [LinkW-1:0] bh [HashBuckets];
  logic [LinkW-1:0] fh, ft, p, n;
  logic [NumBuffers-1:0] pres, lock, cv, dw, wb, onf;
  logic [31:0] tagw;
  logic tagwe;
  logic [SlotW-1:0] s;
  bbcm_out_t res;
  logic to_head;

  always_comb begin
    fn = fn_r; fp = fp_r; cn = cn_r; cp = cp_r; bh = bh_r;
    fh = fh_r; ft = ft_r;
    pres = pres_r; lock = lock_r; cv = cv_r; dw = dw_r; wb = wb_r; onf = onf_r;
    tagw = req_r.block_number; tagwe = 1'b0;
    res = '0; s = '0; p = '0; n = '0; to_head = 1'b0;
    if (req_r.cmd == CmdGet) begin
      if (hit_r) begin
        s = pi;
        res.slot = 4'(s);
        if (lock_r[s]) res.status = StBusy;
        else begin
          res.status = StHit;
          lock[s] = 1'b1;
        end
        res.data_is_valid = cv_r[s];
      end else if (fh_r >= NilLink) begin
        res.status = StNoneFree;
      end else begin
        s = fh_r[SlotW-1:0];
        res.slot = 4'(s);
        lock[s] = 1'b1;
        if (dw_r[s]) begin
          res.status = StWriteback;
          res.victim_block = tag_r[s];
          dw[s] = 1'b0;
          wb[s] = 1'b1;
          res.data_is_valid = cv_r[s];
        end else begin
          if (pres_r[s]) begin
            p = cp_r[s]; n = cn_r[s];
            if (p >= NilLink) bh[bkt(tag_r[s])] = n;
            else cn[p[SlotW-1:0]] = n;
            if (n < NilLink) cp[n[SlotW-1:0]] = p;
          end
          n = bh[bkt(req_r.block_number)];
          cn[s] = n;
          cp[s] = NilLink;
          if (n < NilLink) cp[n[SlotW-1:0]] = LinkW'(s);
          bh[bkt(req_r.block_number)] = LinkW'(s);
          pres[s] = 1'b1;
          tagwe = 1'b1;
          cv[s] = 1'b0;
          wb[s] = 1'b0;
          res.status = StAssigned;
        end
      end
      // free list unlink of the chosen slot (hit or victim)
      if ((hit_r && !lock_r[s]) || (!hit_r && fh_r < NilLink)) begin
        if (onf_r[s]) begin
          p = fp_r[s]; n = fn_r[s];
          if (p >= NilLink) fh = n; else fn[p[SlotW-1:0]] = n;
          if (n >= NilLink) ft = p; else fp[n[SlotW-1:0]] = p;
          fp[s] = NilLink; fn[s] = NilLink; onf[s] = 1'b0;
        end
      end
    end else begin
      s = req_r.buffer_index[SlotW-1:0];
      res.slot = req_r.buffer_index;
      if (32'(req_r.buffer_index) >= 32'(NumBuffers) || !lock_r[s]) begin
        res.status = StNotLocked;
        res.data_is_valid = (32'(req_r.buffer_index) < 32'(NumBuffers)) && cv_r[s];
      end else begin
        res.status = StHit;
        if (req_r.cmd == CmdStatus) begin
          if (req_r.set_valid_flag) cv[s] = 1'b1;
          if (req_r.set_delayed_flag) dw[s] = 1'b1;
        end else begin
          to_head = !cv_r[s] ||
                    (req_r.cmd == CmdWrite && (wb_r[s] || dw_r[s]));
          if (onf_r[s]) begin
            p = fp_r[s]; n = fn_r[s];
            if (p >= NilLink) fh = n; else fn[p[SlotW-1:0]] = n;
            if (n >= NilLink) ft = p; else fp[n[SlotW-1:0]] = p;
          end
          if (!to_head) begin
            fp[s] = ft; fn[s] = NilLink;
            if (ft >= NilLink) fh = LinkW'(s); else fn[ft[SlotW-1:0]] = LinkW'(s);
            ft = LinkW'(s);
          end else begin
            fn[s] = fh; fp[s] = NilLink;
            if (fh >= NilLink) ft = LinkW'(s); else fp[fh[SlotW-1:0]] = LinkW'(s);
            fh = LinkW'(s);
          end
          onf[s] = 1'b1;
          wb[s] = 1'b0;
          lock[s] = 1'b0;
        end
        res.data_is_valid = cv[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= '0; lock_r <= '0; cv_r <= '0; dw_r <= '0; wb_r <= '0;
      onf_r <= '1;
      fh_r <= '0;
      ft_r <= LinkW'(NumBuffers - 1);
      for (int i = 0; i < NumBuffers; i++) begin
        fp_r[i] <= (i == 0) ? NilLink : LinkW'(i - 1);
        fn_r[i] <= LinkW'(i + 1);
        cn_r[i] <= NilLink;
        cp_r[i] <= NilLink;
        tag_r[i] <= '0;
      end
      for (int j = 0; j < HashBuckets; j++) bh_r[j] <= NilLink;
    end else if (ctl.act) begin
      fn_r <= fn; fp_r <= fp; cn_r <= cn; cp_r <= cp; bh_r <= bh;
      fh_r <= fh; ft_r <= ft;
      pres_r <= pres; lock_r <= lock; cv_r <= cv; dw_r <= dw; wb_r <= wb;
      onf_r <= onf;
      if (tagwe) tag_r[s] <= tagw;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
      ptr_r <= bh_r[bkt(in_req.block_number)];
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else if (ctl.step) begin
      if (match) hit_r <= 1'b1;
      else begin
        ptr_r <= cn_r[pi];
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (ctl.act) out_res <= res;
  end
endmodule
`default_nettype wire

[sv/block_buffer_cache_manager.sv]
// Buffer cache manager with hash chains and an LRU free list. One request is
// handled at a time. A get walks its hash-bucket chain one entry per cycle,
// visiting up to 16 entries. The result is registered in the act state, which
// follows acceptance and the walk state (where only a get steps its chain). It is
// held in an output register until taken, and the next request is accepted
// in the cycle after the result leaves.
`default_nettype none
module block_buffer_cache_manager import bbcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  bbcm_in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output bbcm_out_t out_data
);
  bbcm_cmd_t  ctl;
  bbcm_stat_t sts;

  bbcm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .ctl(ctl), .sts(sts)
  );

  bbcm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_data), .ctl(ctl), .sts(sts),
    .out_res(out_data)
  );
endmodule
`default_nettype wire
